/* rtl/spde_pkg.sv */
// spde_pkg: shared types, constants and helpers for the period extremum detector
// used by spde_point_queue and signal_period_extremum_detector; no dependencies

package spde_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 24;
    localparam int CFG_BITS    = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam int MAG_BITS  = SAMPLE_BITS + 1;
    localparam int PROD_BITS = CFG_BITS + MAG_BITS;
    localparam int CMP_BITS  = SAMPLE_BITS + CFG_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam logic [CFG_BITS-1:0] RATIO_RESET = 16'd1971;
    localparam logic [CFG_BITS-1:0] LEVEL_RESET = 16'd0;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MINIMUM_MAXIMUM = 1'd1;

    typedef enum logic {
        KIND_MAX = 1'b0,
        KIND_MIN = 1'b1
    } point_kind_t;

    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_ONE   = 2'd1,
        FILL_FULL  = 2'd2
    } fill_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_stream;
    } in_t;

    typedef struct packed {
        point_kind_t                   point_kind;
        logic        [INDEX_BITS-1:0]  point_index;
        logic signed [SAMPLE_BITS-1:0] point_value;
        logic                          run_last;
    } out_t;

    function automatic logic [MAG_BITS-1:0] magnitude(input logic signed [SAMPLE_BITS-1:0] v);
        logic signed [MAG_BITS-1:0] ext;
        ext = {v[SAMPLE_BITS-1], v};
        magnitude = ext[MAG_BITS-1] ? MAG_BITS'(-ext) : MAG_BITS'(ext);
    endfunction

    // |big| * 256 >= ratio * |small|, exact
    function automatic logic ratio_ok(input logic signed [SAMPLE_BITS-1:0] big,
                                      input logic signed [SAMPLE_BITS-1:0] small_v,
                                      input logic [CFG_BITS-1:0]           ratio);
        logic [PROD_BITS-1:0] lhs;
        logic [PROD_BITS-1:0] rhs;
        lhs = PROD_BITS'({magnitude(big), 8'd0});
        rhs = PROD_BITS'(ratio) * PROD_BITS'(magnitude(small_v));
        ratio_ok = lhs >= rhs;
    endfunction

    function automatic logic above_level(input logic signed [SAMPLE_BITS-1:0] v,
                                         input logic [CFG_BITS-1:0]           level);
        logic signed [CMP_BITS-1:0] ve;
        logic signed [CMP_BITS-1:0] le;
        ve = {{CFG_BITS{v[SAMPLE_BITS-1]}}, v};
        le = {{SAMPLE_BITS{level[CFG_BITS-1]}}, level};
        above_level = ve > le;
    endfunction

endpackage

/* rtl/signal_period_extremum_detector.sv */
// signal_period_extremum_detector: window, extremum hold and period test
// depends on spde_pkg and spde_point_queue
// results: result items are registered into the result queue when their sample item is taken
// throughput: one sample item per cycle; a period gives two result items, and the
// four-entry result queue holds off new samples while fewer than two slots are free
// reset: asynchronous active low; clears state and queue, registers return to 1971 and 0

module signal_period_extremum_detector
    import spde_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  in_t                       sample_item,
    output logic                      point_valid,
    input  logic                      point_ready,
    output out_t                      point_item
);

    localparam logic [INDEX_BITS-1:0] INDEX_TOP = '1;

    logic [CFG_BITS-1:0]           ratio_reg;
    logic [CFG_BITS-1:0]           level_reg;
    fill_t                         fill_reg;
    logic signed [SAMPLE_BITS-1:0] older_reg;
    logic signed [SAMPLE_BITS-1:0] middle_reg;
    logic [INDEX_BITS-1:0]         pos_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic [INDEX_BITS-1:0]         max_index_reg;
    logic                          max_valid_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic [INDEX_BITS-1:0]         min_index_reg;
    logic                          min_valid_reg;

    fill_t                         fill_next;
    logic signed [SAMPLE_BITS-1:0] older_next;
    logic signed [SAMPLE_BITS-1:0] middle_next;
    logic [INDEX_BITS-1:0]         pos_next;
    logic signed [SAMPLE_BITS-1:0] max_next;
    logic [INDEX_BITS-1:0]         max_index_next;
    logic                          max_valid_next;
    logic signed [SAMPLE_BITS-1:0] min_next;
    logic [INDEX_BITS-1:0]         min_index_next;
    logic                          min_valid_next;

    logic                          accept;
    logic                          room_for_two;
    logic signed [SAMPLE_BITS-1:0] s;
    logic [INDEX_BITS-1:0]         mid_index;
    logic                          full;
    logic                          is_min;
    logic                          is_max;
    logic                          min_valid_mid;
    logic                          max_valid_mid;
    logic                          pair_fire;
    logic                          end_fire;
    logic [1:0]                    push_count;
    out_t                          push_first;
    out_t                          push_second;

    assign sample_ready = room_for_two;
    assign accept       = sample_valid && sample_ready;
    assign s            = sample_item.sample;
    assign full         = fill_reg == FILL_FULL;
    assign mid_index    = pos_reg - 1'b1;

    always_comb
    begin
        is_min = full && (older_reg >= middle_reg) && (middle_reg <= s)
                 && (!min_valid_reg || (middle_reg < min_reg));
        is_max = full && (older_reg <= middle_reg) && (middle_reg >= s)
                 && (!max_valid_reg || (middle_reg > max_reg))
                 && above_level(middle_reg, level_reg);

        min_next       = is_min ? middle_reg : min_reg;
        min_index_next = is_min ? mid_index : min_index_reg;
        max_next       = is_max ? middle_reg : max_reg;
        max_index_next = is_max ? mid_index : max_index_reg;
        max_valid_mid  = max_valid_reg || is_max;
        min_valid_mid  = (min_valid_reg || is_min) && !is_max;

        pair_fire = full && max_valid_mid && min_valid_mid
                    && ratio_ok(max_next, min_next, ratio_reg);
        end_fire  = sample_item.end_of_stream && !pair_fire && max_valid_mid
                    && above_level(max_next, level_reg)
                    && ratio_ok(max_next, s, ratio_reg);

        push_first.point_kind   = KIND_MAX;
        push_first.point_index  = max_index_next;
        push_first.point_value  = max_next;
        push_first.run_last     = !pair_fire;
        push_second.point_kind  = KIND_MIN;
        push_second.point_index = min_index_next;
        push_second.point_value = min_next;
        push_second.run_last    = 1'b1;

        push_count = 2'd0;
        if (accept)
        begin
            if (pair_fire)
            begin
                push_count = 2'd2;
            end
            else if (end_fire)
            begin
                push_count = 2'd1;
            end
        end

        pos_next    = (pos_reg == INDEX_TOP) ? pos_reg : pos_reg + 1'b1;
        fill_next   = fill_reg;
        older_next  = older_reg;
        middle_next = middle_reg;
        unique case (fill_reg)
            FILL_EMPTY:
            begin
                older_next = s;
                fill_next  = FILL_ONE;
            end
            FILL_ONE:
            begin
                middle_next = s;
                fill_next   = FILL_FULL;
            end
            default:
            begin
                older_next  = middle_reg;
                middle_next = s;
            end
        endcase
        max_valid_next = max_valid_mid && !pair_fire;
        min_valid_next = min_valid_mid && !pair_fire;

        if (sample_item.end_of_stream)
        begin
            fill_next      = FILL_EMPTY;
            pos_next       = '0;
            max_valid_next = 1'b0;
            min_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
            level_reg <= LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RATIO_THRESHOLD: ratio_reg <= cfg_data;
                REG_MINIMUM_MAXIMUM: level_reg <= cfg_data;
                default:             ratio_reg <= ratio_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= FILL_EMPTY;
            pos_reg       <= '0;
            max_valid_reg <= 1'b0;
            min_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            max_valid_reg <= max_valid_next;
            min_valid_reg <= min_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_reg     <= older_next;
            middle_reg    <= middle_next;
            max_reg       <= max_next;
            max_index_reg <= max_index_next;
            min_reg       <= min_next;
            min_index_reg <= min_index_next;
        end
    end

    spde_point_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push_first   (push_first),
        .push_second  (push_second),
        .room_for_two (room_for_two),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point_item   (point_item)
    );

endmodule

/* rtl/spde_point_queue.sv */
// spde_point_queue: small result queue taking up to two items per cycle
// depends on spde_pkg

module spde_point_queue
    import spde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  out_t       push_first,
    input  out_t       push_second,
    output logic       room_for_two,
    output logic       point_valid,
    input  logic       point_ready,
    output out_t       point_item
);

    out_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QPTR_BITS-1:0] wr_ptr_plus_one;
    logic                 pop;

    assign wr_ptr_plus_one = wr_ptr_reg + 1'b1;
    assign point_valid     = count_reg != '0;
    assign point_item      = mem[rd_ptr_reg];
    assign pop             = point_valid && point_ready;
    assign room_for_two    = count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_plus_one] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(push_count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_BITS'(push_count) - QCNT_BITS'(pop);
        end
    end

endmodule

/* test/signal_period_extremum_detector_tb.sv */
// testbench for signal_period_extremum_detector: drives sample items with random gaps,
// predicts the period extremum results and checks every result item in order
// depends on spde_pkg and the detector rtl
`timescale 1ns / 100ps

module testbench;
    import spde_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_OFF_AT   = 150;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int DRAIN_CYCLES  = 6;
    localparam int PRINT_LIMIT   = 40;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data = '0;
    logic                      sample_valid = 1'b0;
    logic                      sample_ready;
    in_t                       sample_item = '0;
    logic                      point_valid;
    logic                      point_ready = 1'b0;
    out_t                      point_item;

    in_t  pending[$];
    out_t expected_points[$];

    int cycle_count = 0;
    int fail_count = 0;
    int samples_taken = 0;
    int samples_queued = 0;
    int points_checked = 0;
    int settings_count = 1;
    int send_gap = 0;
    int recv_wait = 0;
    int hold_off_left = 0;
    bit hold_off_done = 1'b0;

    // register copies
    logic        [CFG_BITS-1:0] ratio_cfg = RATIO_RESET;
    logic signed [CFG_BITS-1:0] level_cfg = LEVEL_RESET;

    // tracked detector state
    fill_t                         win_fill;
    logic signed [SAMPLE_BITS-1:0] older_s;
    logic signed [SAMPLE_BITS-1:0] middle_s;
    logic        [INDEX_BITS-1:0]  next_pos;
    logic signed [SAMPLE_BITS-1:0] max_val;
    logic        [INDEX_BITS-1:0]  max_pos;
    logic                          max_held;
    logic signed [SAMPLE_BITS-1:0] min_val;
    logic        [INDEX_BITS-1:0]  min_pos;
    logic                          min_held;

    signal_period_extremum_detector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point_item   (point_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    function automatic bit ratio_pass(input logic signed [SAMPLE_BITS-1:0] big,
                                      input logic signed [SAMPLE_BITS-1:0] small_v,
                                      input logic        [CFG_BITS-1:0]    ratio);
        longint mag_big;
        longint mag_small;
        mag_big   = (big < 0) ? -longint'(big) : longint'(big);
        mag_small = (small_v < 0) ? -longint'(small_v) : longint'(small_v);
        return mag_big * 256 >= longint'({1'b0, ratio}) * mag_small;
    endfunction

    function automatic out_t point_of(input point_kind_t kind,
                                      input logic [INDEX_BITS-1:0] pos,
                                      input logic signed [SAMPLE_BITS-1:0] value,
                                      input logic last);
        out_t p;
        p.point_kind  = kind;
        p.point_index = pos;
        p.point_value = value;
        p.run_last    = last;
        return p;
    endfunction

    task automatic clear_tracking();
        win_fill = FILL_EMPTY;
        older_s  = '0;
        middle_s = '0;
        next_pos = '0;
        max_val  = '0;
        max_pos  = '0;
        max_held = 1'b0;
        min_val  = '0;
        min_pos  = '0;
        min_held = 1'b0;
    endtask

    task automatic predict_sample(input in_t it);
        logic signed [SAMPLE_BITS-1:0] s;
        logic        [INDEX_BITS-1:0]  pos;
        logic        [INDEX_BITS-1:0]  mid_pos;
        s   = it.sample;
        pos = next_pos;
        next_pos = (pos == '1) ? pos : pos + 1'b1;
        case (win_fill)
            FILL_EMPTY:
            begin
                older_s  = s;
                win_fill = FILL_ONE;
            end
            FILL_ONE:
            begin
                middle_s = s;
                win_fill = FILL_FULL;
            end
            default:
            begin
                mid_pos = pos - 1'b1;
                if (older_s >= middle_s && middle_s <= s && (!min_held || middle_s < min_val))
                begin
                    min_val  = middle_s;
                    min_pos  = mid_pos;
                    min_held = 1'b1;
                end
                if (older_s <= middle_s && middle_s >= s && (!max_held || middle_s > max_val)
                    && middle_s > level_cfg)
                begin
                    max_val  = middle_s;
                    max_pos  = mid_pos;
                    max_held = 1'b1;
                    min_held = 1'b0;
                end
                if (max_held && min_held && ratio_pass(max_val, min_val, ratio_cfg))
                begin
                    expected_points.push_back(point_of(KIND_MAX, max_pos, max_val, 1'b0));
                    expected_points.push_back(point_of(KIND_MIN, min_pos, min_val, 1'b1));
                    max_held = 1'b0;
                    min_held = 1'b0;
                end
                older_s  = middle_s;
                middle_s = s;
            end
        endcase
        if (it.end_of_stream)
        begin
            if (max_held && max_val > level_cfg && ratio_pass(max_val, s, ratio_cfg))
                expected_points.push_back(point_of(KIND_MAX, max_pos, max_val, 1'b1));
            clear_tracking();
        end
    endtask

    task automatic check_point(input out_t got);
        out_t want;
        if (expected_points.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result item kind %0d index %0d value %0d",
                                      got.point_kind, got.point_index, got.point_value));
        end
        else
        begin
            want = expected_points.pop_front();
            if (got.point_kind !== want.point_kind)
                report_mismatch($sformatf("point_kind %0d, want %0d",
                                          got.point_kind, want.point_kind));
            if (got.point_index !== want.point_index)
                report_mismatch($sformatf("point_index %0d, want %0d",
                                          got.point_index, want.point_index));
            if (got.point_value !== want.point_value)
                report_mismatch($sformatf("point_value %0d, want %0d",
                                          got.point_value, want.point_value));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %0d, want %0d",
                                          got.run_last, want.run_last));
        end
        points_checked++;
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_item  <= '0;
            send_gap     <= 0;
            clear_tracking();
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                predict_sample(sample_item);
                samples_taken <= samples_taken + 1;
            end
            if (!sample_valid || sample_ready)
            begin
                if (send_gap != 0)
                begin
                    sample_valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end
                else if (pending.size() != 0)
                begin
                    sample_valid <= 1'b1;
                    sample_item  <= pending.pop_front();
                    send_gap     <= $urandom_range(0, 8);
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the result queue fills and input stalls
    always @(posedge clk)
    begin
        if (!hold_off_done && samples_taken == HOLD_OFF_AT)
        begin
            hold_off_left <= HOLD_OFF_LEN;
            hold_off_done <= 1'b1;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : point_monitor
        int wait_next;
        if (!rst_n)
        begin
            point_ready <= 1'b0;
            recv_wait   <= 0;
        end
        else
        begin
            wait_next = recv_wait;
            if (point_valid && point_ready)
            begin
                check_point(point_item);
                wait_next = $urandom_range(0, 8);
            end
            else if (wait_next != 0)
            begin
                wait_next = wait_next - 1;
            end
            recv_wait   <= wait_next;
            point_ready <= (wait_next == 0) && (hold_off_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("signal_period_extremum_detector regression: fail");
            $finish;
        end
    end

    task automatic queue_sample(input int value, input bit last);
        in_t it;
        it.sample        = SAMPLE_BITS'(value);
        it.end_of_stream = last;
        pending.push_back(it);
        samples_queued++;
    endtask

    // one stream of ramps between peaks and troughs, closed by an end mark
    task automatic queue_wave();
        int cycles;
        int level;
        int peak;
        int trough;
        int mag;
        int steps;
        int c;
        int k;
        cycles = $urandom_range(1, 5);
        level  = $urandom_range(0, 200) - 100;
        for (c = 0; c < cycles; c++)
        begin
            if ($urandom_range(0, 7) == 0)
                peak = $urandom_range(0, 65535) - 32768;
            else
                peak = $urandom_range(0, 32767);
            case ($urandom_range(0, 3))
                0: mag = 0;
                1: mag = $urandom_range(0, 64);
                2: mag = $urandom_range(0, 4000);
                default: mag = 32768;
            endcase
            trough = $urandom_range(0, 2 * mag) - mag;
            if (trough > 32767)
                trough = 32767;
            steps = $urandom_range(1, 3);
            for (k = 1; k <= steps; k++)
                queue_sample(level + (peak - level) * k / steps, 1'b0);
            level = peak;
            steps = $urandom_range(1, 3);
            for (k = 1; k <= steps; k++)
                queue_sample(level + (trough - level) * k / steps, 1'b0);
            level = trough;
        end
        if ($urandom_range(0, 3) == 0)
            queue_sample($urandom_range(0, 65535) - 32768, 1'b1);
        else
            queue_sample($urandom_range(0, 512) - 256, 1'b1);
    endtask

    task automatic queue_random(input int count);
        int target;
        int n;
        int k;
        target = samples_queued + count;
        while (samples_queued < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                queue_wave();
            end
            else
            begin
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                    queue_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 15) == 0);
            end
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || sample_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_RATIO_THRESHOLD)
            ratio_cfg = value;
        else
            level_cfg = value;
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] ratio,
                             input logic [CFG_BITS-1:0] level,
                             input int count);
        drain();
        write_reg(REG_RATIO_THRESHOLD, ratio);
        write_reg(REG_MINIMUM_MAXIMUM, level);
        settings_count++;
        queue_random(count);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at the reset register values
        queue_sample(7, 1'b1);
        queue_sample(3, 1'b0);
        queue_sample(-2, 1'b1);
        queue_sample(0, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(4, 1'b0);
        queue_sample(4, 1'b0);
        queue_sample(4, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(20000, 1'b0);
        queue_sample(5, 1'b0);
        queue_sample(3, 1'b1);
        queue_sample(100, 1'b0);
        queue_sample(200, 1'b0);
        queue_sample(100, 1'b0);
        queue_sample(-32768, 1'b1);

        // every period passes, long hold-off lands here
        run_phase(16'd0, 16'h8000, 300);
        // no maximum can count
        run_phase(16'hFFFF, 16'h7FFF, 100);
        run_phase(RATIO_RESET, LEVEL_RESET, 300);
        // a minimum passes only if 256 times the maximum's magnitude reaches 65535 times its own
        run_phase(16'hFFFF, 16'h8000, 100);
        repeat (3)
            run_phase(CFG_BITS'($urandom_range(0, 4096)),
                      CFG_BITS'($urandom_range(0, 2000) - 1000), 120);
        drain();

        $display("covered %0d sample items and %0d result items over %0d register settings,",
                 samples_taken, points_checked, settings_count);
        $display("with a %0d-cycle receiver hold-off that stalled the sample input",
                 HOLD_OFF_LEN);
        if (fail_count == 0 && expected_points.size() == 0)
            $display("signal_period_extremum_detector regression: pass");
        else
            $display("signal_period_extremum_detector regression: fail");
        $finish;
    end

endmodule
